@@ rtl/core/kstacc_pkg.sv @@
// ----------------------------------------------------------------------------
// kstacc_pkg
// Shared widths, defaults and sequencer codes for the kinetic tensor core.
// ----------------------------------------------------------------------------
package kstacc_pkg;

  localparam int MASS_BITS_DEF     = 16;
  localparam int VELOCITY_BITS_DEF = 18;

  localparam int SUM_W  = 64;  // signed accumulator / off-diagonal width
  localparam int DIAG_W = 63;  // diagonal and energy result width
  localparam int NUM_SLOTS = 6;

  typedef logic [1:0] period_t;
  localparam period_t PERIOD_FULL  = 2'd3;
  localparam period_t PERIOD_TWO   = 2'd2;
  localparam period_t PERIOD_RESET = 2'd3;

  // Sequencer op codes, issued to the shared multiplier in this order.
  typedef logic [3:0] op_t;
  localparam op_t OP_MX  = 4'd0;  // mass * |vx|
  localparam op_t OP_MY  = 4'd1;
  localparam op_t OP_MZ  = 4'd2;
  localparam op_t OP_XX  = 4'd3;  // (mass*|vx|) * |vx|
  localparam op_t OP_YY  = 4'd4;
  localparam op_t OP_ZZ  = 4'd5;
  localparam op_t OP_XY  = 4'd6;
  localparam op_t OP_XZ  = 4'd7;
  localparam op_t OP_YZ  = 4'd8;
  localparam op_t OP_END = 4'd9;  // retire-only step

  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_XX = 3'd0;
  localparam slot_t SLOT_YY = 3'd1;
  localparam slot_t SLOT_ZZ = 3'd2;
  localparam slot_t SLOT_XY = 3'd3;
  localparam slot_t SLOT_XZ = 3'd4;
  localparam slot_t SLOT_YZ = 3'd5;

endpackage

@@ rtl/core/kinetic_stress_tensor_accumulate_core.sv @@
// ----------------------------------------------------------------------------
// kinetic_stress_tensor_accumulate_core
// Accumulates m*vi*vj per atom and emits the tensor, masked by periodicity, and kinetic energy.
// ----------------------------------------------------------------------------
// One atom request is taken when in_ready is high; the core then runs nine
// multiplies (three mass*|v| partials, six tensor products) through a single
// shared multiplier with a registered product, retiring each tensor product
// into its saturating accumulator in the following cycle. in_ready returns
// once the sequencer has stepped OP_MX..OP_END for an ordinary atom; an atom
// flagged last_atom passes ST_SUM (diagonal sum), then ST_EMIT (energy and
// result load), and waits further only if the previous result is still held
// in the output register. Results appear on the out channel, one per batch.
// ----------------------------------------------------------------------------
module kinetic_stress_tensor_accumulate_core #(
  parameter int MASS_BITS     = kstacc_pkg::MASS_BITS_DEF,
  parameter int VELOCITY_BITS = kstacc_pkg::VELOCITY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  kstacc_pkg::period_t               cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [MASS_BITS-1:0]              atom_mass,
  input  logic signed [VELOCITY_BITS-1:0]   vel_x,
  input  logic signed [VELOCITY_BITS-1:0]   vel_y,
  input  logic signed [VELOCITY_BITS-1:0]   vel_z,
  input  logic                              last_atom,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kstacc_pkg::DIAG_W-1:0]     tensor_xx,
  output logic [kstacc_pkg::DIAG_W-1:0]     tensor_yy,
  output logic [kstacc_pkg::DIAG_W-1:0]     tensor_zz,
  output logic signed [kstacc_pkg::SUM_W-1:0] tensor_xy,
  output logic signed [kstacc_pkg::SUM_W-1:0] tensor_xz,
  output logic signed [kstacc_pkg::SUM_W-1:0] tensor_yz,
  output logic [kstacc_pkg::DIAG_W-1:0]     kinetic_energy
);
  import kstacc_pkg::*;

  localparam int VB = VELOCITY_BITS;
  localparam int AW = MASS_BITS + VELOCITY_BITS;  // mass * |v|
  localparam int PW = AW + VELOCITY_BITS;         // full product

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_SUM, ST_EMIT} state_t;

  state_t          state;
  op_t             cnt;
  period_t         periodicity;

  logic [AW-1:0]   mass;
  logic [VB-1:0]   mag_x, mag_y, mag_z;
  logic            neg_x, neg_y, neg_z;
  logic            last;
  logic [AW-1:0]   mvx, mvy, mvz;
  logic [PW-1:0]   prod;
  logic [SUM_W-1:0] sum_s;

  logic signed [SUM_W-1:0] sums [NUM_SLOTS];

  // multiplier operand select
  logic [AW-1:0]   mul_a;
  logic [VB-1:0]   mul_b;

  always_comb begin
    case (cnt)
      OP_MX: begin mul_a = mass; mul_b = mag_x; end
      OP_MY: begin mul_a = mass; mul_b = mag_y; end
      OP_MZ: begin mul_a = mass; mul_b = mag_z; end
      OP_XX: begin mul_a = mvx;  mul_b = mag_x; end
      OP_YY: begin mul_a = mvy;  mul_b = mag_y; end
      OP_ZZ: begin mul_a = mvz;  mul_b = mag_z; end
      OP_XY: begin mul_a = mvx;  mul_b = mag_y; end
      OP_XZ: begin mul_a = mvx;  mul_b = mag_z; end
      OP_YZ: begin mul_a = mvy;  mul_b = mag_z; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // retire side: product issued last cycle
  op_t   rop;
  op_t   rslot_w;
  slot_t rslot;
  logic  rneg;
  logic  racc_en;

  assign rop     = cnt - 4'd1;
  assign rslot_w = rop - OP_XX;
  assign rslot   = rslot_w[2:0];

  always_comb begin
    case (rslot)
      SLOT_XY: rneg = neg_x ^ neg_y;
      SLOT_XZ: rneg = neg_x ^ neg_z;
      SLOT_YZ: rneg = neg_y ^ neg_z;
      default: rneg = 1'b0;
    endcase
  end

  assign racc_en = (state == ST_RUN) && (cnt > OP_MZ) &&
                   ((rslot < SLOT_XZ) || (periodicity == PERIOD_FULL));

  // saturating accumulate
  logic signed [SUM_W:0]   addend;
  logic signed [SUM_W:0]   acc_sum;
  logic signed [SUM_W-1:0] acc_sat;
  logic signed [SUM_W-1:0] acc_cur;

  assign acc_cur = sums[rslot];
  assign addend  = rneg ? -$signed((SUM_W+1)'(prod)) : $signed((SUM_W+1)'(prod));
  assign acc_sum = {acc_cur[SUM_W-1], acc_cur} + addend;

  always_comb begin
    if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
      acc_sat = acc_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[SUM_W-1:0];
    end
  end

  // diagonals never go below zero, clamp anyway
  logic [SUM_W-1:0] dx, dy, dz;
  assign dx = sums[SLOT_XX][SUM_W-1] ? '0 : sums[SLOT_XX];
  assign dy = sums[SLOT_YY][SUM_W-1] ? '0 : sums[SLOT_YY];
  assign dz = sums[SLOT_ZZ][SUM_W-1] ? '0 : sums[SLOT_ZZ];

  logic [SUM_W:0]   e_total;
  logic [SUM_W-1:0] e_half;
  logic [DIAG_W-1:0] e_sat;

  assign e_total = {1'b0, sum_s} + {1'b0, dz};
  assign e_half  = e_total[SUM_W:1];
  assign e_sat   = e_half[SUM_W-1] ? '1 : e_half[DIAG_W-1:0];

  logic [VB-1:0] vx_neg, vy_neg, vz_neg;
  assign vx_neg = ~vel_x + 1'b1;
  assign vy_neg = ~vel_y + 1'b1;
  assign vz_neg = ~vel_z + 1'b1;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= OP_MX;
      periodicity <= PERIOD_RESET;
      out_valid   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) sums[i] <= '0;
    end else begin
      if (cfg_wr_en) periodicity <= cfg_wr_data;
      // ST_EMIT reloads the output register itself when it is freed
      if (out_valid && out_ready && (state != ST_EMIT)) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mass  <= AW'(atom_mass);
            neg_x <= vel_x[VB-1];
            neg_y <= vel_y[VB-1];
            neg_z <= vel_z[VB-1];
            mag_x <= vel_x[VB-1] ? vx_neg : vel_x;
            mag_y <= vel_y[VB-1] ? vy_neg : vel_y;
            mag_z <= vel_z[VB-1] ? vz_neg : vel_z;
            last  <= last_atom;
            cnt   <= OP_MX;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          prod <= mul_a * mul_b;
          if (cnt != OP_MX) begin
            case (rop)
              OP_MX: mvx <= prod[AW-1:0];
              OP_MY: mvy <= prod[AW-1:0];
              OP_MZ: mvz <= prod[AW-1:0];
              default: begin
                if (racc_en) sums[rslot] <= acc_sat;
              end
            endcase
          end
          if (cnt == OP_END) begin
            state <= last ? ST_SUM : ST_IDLE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_SUM: begin
          sum_s <= dx + dy;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (periodicity >= PERIOD_TWO) begin
              tensor_xx <= dx[DIAG_W-1:0];
              tensor_yy <= dy[DIAG_W-1:0];
              tensor_zz <= dz[DIAG_W-1:0];
              tensor_xy <= sums[SLOT_XY];
            end else begin
              tensor_xx <= '0;
              tensor_yy <= '0;
              tensor_zz <= '0;
              tensor_xy <= '0;
            end
            if (periodicity == PERIOD_FULL) begin
              tensor_xz <= sums[SLOT_XZ];
              tensor_yz <= sums[SLOT_YZ];
            end else begin
              tensor_xz <= '0;
              tensor_yz <= '0;
            end
            kinetic_energy <= e_sat;
            out_valid      <= 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) sums[i] <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/kstacc_checker.sv @@
// ----------------------------------------------------------------------------
// kstacc_checker
// Port-level checks for the kinetic tensor core, bound to the core module.
// ----------------------------------------------------------------------------
module kstacc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kstacc_pkg::DIAG_W-1:0] kinetic_energy,
  input logic [kstacc_pkg::SUM_W-1:0]  tensor_xy
);
  import kstacc_pkg::*;

  // core is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted request");

  // a result is only loaded from the busy sequencer, never while idle
  a_emit_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while core was idle");

  // no new result while none is held and the core is idle
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && in_ready) |=> !out_valid)
    else $error("result without sequencer work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kinetic_energy) &&
                                   $stable(tensor_xy)))
    else $error("stalled result changed");

endmodule

bind kinetic_stress_tensor_accumulate_core kstacc_checker u_kstacc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .kinetic_energy (kinetic_energy),
  .tensor_xy      (tensor_xy)
);
